>>> design/sha256_pkg.sv
// ----------------------------------------------------------------------------
// sha256_pkg
// Shared types, round constants and helper functions for the SHA-256/224
// engine.
// ----------------------------------------------------------------------------
package sha256_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned BlkWds  = 16;
  localparam int unsigned HashWds = 8;

  localparam logic VAR_SHA256 = 1'b0;
  localparam logic VAR_SHA224 = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_GO, ST_WAIT, ST_PAD, ST_FILL, ST_CLR, ST_LEN, ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    C_IDLE, C_RUN, C_ADD
  } core_state_t;

  typedef struct packed {
    logic start;
    logic load_iv;
    logic variant;
  } core_cmd_t;

  function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned n);
    ror = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    bsig0 = ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    bsig1 = ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    ssig0 = ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    ssig1 = ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] iv_word(input logic variant, input logic [2:0] i);
    logic [31:0] r;
    r = '0;
    if (variant == VAR_SHA224) begin
      case (i)
        3'd0: r = 32'hc1059ed8;
        3'd1: r = 32'h367cd507;
        3'd2: r = 32'h3070dd17;
        3'd3: r = 32'hf70e5939;
        3'd4: r = 32'hffc00b31;
        3'd5: r = 32'h68581511;
        3'd6: r = 32'h64f98fa7;
        default: r = 32'hbefa4fa4;
      endcase
    end else begin
      case (i)
        3'd0: r = 32'h6a09e667;
        3'd1: r = 32'hbb67ae85;
        3'd2: r = 32'h3c6ef372;
        3'd3: r = 32'ha54ff53a;
        3'd4: r = 32'h510e527f;
        3'd5: r = 32'h9b05688c;
        3'd6: r = 32'h1f83d9ab;
        default: r = 32'h5be0cd19;
      endcase
    end
    iv_word = r;
  endfunction

  function automatic logic [31:0] k_const(input logic [5:0] t);
    logic [31:0] r;
    case (t)
      6'd0: r = 32'h428a2f98;  6'd1: r = 32'h71374491;  6'd2: r = 32'hb5c0fbcf;
      6'd3: r = 32'he9b5dba5;  6'd4: r = 32'h3956c25b;  6'd5: r = 32'h59f111f1;
      6'd6: r = 32'h923f82a4;  6'd7: r = 32'hab1c5ed5;  6'd8: r = 32'hd807aa98;
      6'd9: r = 32'h12835b01;  6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
      6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe; 6'd14: r = 32'h9bdc06a7;
      6'd15: r = 32'hc19bf174; 6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
      6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc; 6'd20: r = 32'h2de92c6f;
      6'd21: r = 32'h4a7484aa; 6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
      6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d; 6'd26: r = 32'hb00327c8;
      6'd27: r = 32'hbf597fc7; 6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
      6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967; 6'd32: r = 32'h27b70a85;
      6'd33: r = 32'h2e1b2138; 6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
      6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb; 6'd38: r = 32'h81c2c92e;
      6'd39: r = 32'h92722c85; 6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
      6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3; 6'd44: r = 32'hd192e819;
      6'd45: r = 32'hd6990624; 6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
      6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08; 6'd50: r = 32'h2748774c;
      6'd51: r = 32'h34b0bcb5; 6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
      6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3; 6'd56: r = 32'h748f82ee;
      6'd57: r = 32'h78a5636f; 6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
      6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb; 6'd62: r = 32'hbef9a3f7;
      default: r = 32'hc67178f2;
    endcase
    k_const = r;
  endfunction

endpackage

>>> design/sha256_core.sv
// ----------------------------------------------------------------------------
// sha256_core
// Iterative compression unit: one round per cycle over a 16-word schedule
// window, then a fold step (C_ADD) that adds the working variables into the hash.
// ----------------------------------------------------------------------------
module sha256_core (
  input  logic                  clk,
  input  logic                  rst,
  input  sha256_pkg::core_cmd_t cmd,
  input  logic [31:0]           blk [16],
  output logic [31:0]           hash [8],
  output logic                  done
);

  sha256_pkg::core_state_t state, state_next;
  logic [5:0]  rnd;
  logic [31:0] v [8];
  logic [31:0] w [16];
  logic [31:0] t1, t2, w_new, ch, maj;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      sha256_pkg::C_IDLE: if (cmd.start) state_next = sha256_pkg::C_RUN;
      sha256_pkg::C_RUN:  if (rnd == 6'd63) state_next = sha256_pkg::C_ADD;
      sha256_pkg::C_ADD:  state_next = sha256_pkg::C_IDLE;
      default:            state_next = sha256_pkg::C_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    done = (state == sha256_pkg::C_ADD);
  end

  // round and schedule arithmetic
  always_comb begin
    ch    = (v[4] & v[5]) ^ (~v[4] & v[6]);
    maj   = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t1    = v[7] + sha256_pkg::bsig1(v[4]) + ch + sha256_pkg::k_const(rnd) + w[0];
    t2    = sha256_pkg::bsig0(v[0]) + maj;
    w_new = sha256_pkg::ssig1(w[14]) + w[9] + sha256_pkg::ssig0(w[1]) + w[0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sha256_pkg::C_IDLE;
      rnd   <= '0;
    end else begin
      state <= state_next;
      if (state == sha256_pkg::C_RUN) rnd <= rnd + 6'd1;
      else rnd <= '0;
    end
  end

  // working variables and schedule window
  always_ff @(posedge clk) begin
    if (state == sha256_pkg::C_IDLE && cmd.start) begin
      for (int i = 0; i < 16; i++) w[i] <= blk[i];
      for (int i = 0; i < 8; i++) v[i] <= hash[i];
    end else if (state == sha256_pkg::C_RUN) begin
      for (int i = 0; i < 15; i++) w[i] <= w[i+1];
      w[15] <= w_new;
      v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4]; v[4] <= v[3] + t1;
      v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0]; v[0] <= t1 + t2;
    end
  end

  // hash words: reload or accumulate
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 8; i++) hash[i] <= sha256_pkg::iv_word(sha256_pkg::VAR_SHA256, 3'(i));
    end else if (cmd.load_iv) begin
      for (int i = 0; i < 8; i++) hash[i] <= sha256_pkg::iv_word(cmd.variant, 3'(i));
    end else if (state == sha256_pkg::C_ADD) begin
      for (int i = 0; i < 8; i++) hash[i] <= hash[i] + v[i];
    end
  end

endmodule

>>> design/sha256_hash_engine_top.sv
// ----------------------------------------------------------------------------
// sha256_hash_engine_top
// SHA-256 / SHA-224 engine over a stream of big-endian 32-bit words.
// ----------------------------------------------------------------------------
// Input beats (s_axis) carry one message word and its valid byte count; tlast
// marks the final word, whose valid bytes sit in the top positions. Output
// beats (m_axis) carry the digest, 8 words for SHA-256 or 7 for SHA-224,
// with tlast on the final word. The cfg channel writes the variant bit
// (0 = SHA-256, 1 = SHA-224); a write reloads the initial hash and drops
// any message in progress. Write it only while the engine is idle.
// A word that does not complete a block only goes into the buffer. A word
// that completes a block also starts the core: a load step, the 64 rounds
// through the shared round unit and a fold step. After the final word the
// engine adds the pad word, zero fill and the bit length and hashes the
// last block; with two padding blocks it first hashes the one holding the
// pad word. Sustained rate is set by the 64 rounds of the single round
// unit. The engine takes one word at a time and s_axis_tready is low while
// it works or while digest beats wait.
// A stalled receiver holds the current digest beat. Reset (rst, synchronous)
// loads the SHA-256 initial values and clears the buffer fill and length.
// ----------------------------------------------------------------------------
module sha256_hash_engine_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // [31:0] data_word, [34:32] byte_count
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] digest_word, [34:32] word_index
  output logic        m_axis_tlast
);

  sha256_pkg::state_t    state, state_next, ret_state, ret_next;
  sha256_pkg::core_cmd_t cmd;
  logic [31:0] buffer [16];
  logic [31:0] hash [8];
  logic        done;
  logic        variant;
  logic [3:0]  fill;
  logic [63:0] bit_length;
  logic [31:0] pad_word, pad_calc;
  logic [2:0]  out_idx;
  logic [2:0]  cnt;
  logic        in_beat, out_beat, cfg_beat, out_end;
  logic [31:0] in_word;

  assign in_word  = s_axis_tdata[31:0];
  assign cnt      = (s_axis_tdata[34:32] > 3'd4) ? 3'd4 : s_axis_tdata[34:32];
  assign in_beat  = s_axis_tvalid && s_axis_tready;
  assign out_beat = m_axis_tvalid && m_axis_tready;
  assign cfg_beat = cfg_valid && cfg_ready;
  assign out_end  = (out_idx == ((variant == sha256_pkg::VAR_SHA224) ? 3'd6 : 3'd7));

  // padding word for the final beat
  always_comb begin
    case (cnt)
      3'd0:    pad_calc = 32'h8000_0000;
      3'd1:    pad_calc = {in_word[31:24], 24'h80_0000};
      3'd2:    pad_calc = {in_word[31:16], 16'h8000};
      3'd3:    pad_calc = {in_word[31:8], 8'h80};
      default: pad_calc = 32'h8000_0000;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    ret_next   = ret_state;
    case (state)
      sha256_pkg::ST_IDLE: begin
        if (in_beat) begin
          if (!s_axis_tlast) begin
            if (fill == 4'd15) begin
              state_next = sha256_pkg::ST_GO;
              ret_next   = sha256_pkg::ST_IDLE;
            end
          end else if (cnt == 3'd4 && fill == 4'd15) begin
            state_next = sha256_pkg::ST_GO;
            ret_next   = sha256_pkg::ST_PAD;
          end else begin
            state_next = sha256_pkg::ST_PAD;
          end
        end
      end
      sha256_pkg::ST_GO:   state_next = sha256_pkg::ST_WAIT;
      sha256_pkg::ST_WAIT: if (done) state_next = ret_state;
      sha256_pkg::ST_PAD: begin
        if (fill == 4'd15) begin
          state_next = sha256_pkg::ST_GO;
          ret_next   = sha256_pkg::ST_CLR;
        end else begin
          state_next = sha256_pkg::ST_FILL;
        end
      end
      sha256_pkg::ST_FILL: begin
        if (fill == 4'd15) begin
          state_next = sha256_pkg::ST_GO;
          ret_next   = sha256_pkg::ST_CLR;
        end else begin
          state_next = sha256_pkg::ST_LEN;
        end
      end
      sha256_pkg::ST_CLR: state_next = sha256_pkg::ST_LEN;
      sha256_pkg::ST_LEN: begin
        state_next = sha256_pkg::ST_GO;
        ret_next   = sha256_pkg::ST_OUT;
      end
      sha256_pkg::ST_OUT: if (out_beat && out_end) state_next = sha256_pkg::ST_IDLE;
      default: state_next = sha256_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    s_axis_tready = (state == sha256_pkg::ST_IDLE);
    cfg_ready     = 1'b1;
    m_axis_tvalid = (state == sha256_pkg::ST_OUT);
    m_axis_tdata  = {5'd0, out_idx, hash[out_idx]};
    m_axis_tlast  = out_end;
    cmd.start     = (state == sha256_pkg::ST_GO);
    cmd.load_iv   = cfg_beat || (out_beat && out_end);
    cmd.variant   = cfg_beat ? cfg_data : variant;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= sha256_pkg::ST_IDLE;
      ret_state  <= sha256_pkg::ST_IDLE;
      variant    <= sha256_pkg::VAR_SHA256;
      fill       <= '0;
      bit_length <= '0;
      out_idx    <= '0;
    end else begin
      state     <= state_next;
      ret_state <= ret_next;
      if (cfg_beat) variant <= cfg_data;
      if (cmd.load_iv) begin
        fill       <= '0;
        bit_length <= '0;
        out_idx    <= '0;
      end else begin
        if (in_beat) begin
          if (!s_axis_tlast) bit_length <= bit_length + 64'd32;
          else bit_length <= bit_length + {58'd0, cnt, 3'd0};
          if (!s_axis_tlast || cnt == 3'd4) fill <= fill + 4'd1;
        end
        if (state == sha256_pkg::ST_PAD) fill <= fill + 4'd1;
        if (out_beat) out_idx <= out_idx + 3'd1;
      end
    end
  end

  // capture the padding word with the data word and hold it for ST_PAD
  always_ff @(posedge clk) begin
    if (in_beat) pad_word <= pad_calc;
  end

  // block buffer
  always_ff @(posedge clk) begin
    if (in_beat && (!s_axis_tlast || cnt == 3'd4)) begin
      buffer[fill] <= in_word;
    end else if (state == sha256_pkg::ST_PAD) begin
      buffer[fill] <= pad_word;
    end else if (state == sha256_pkg::ST_FILL) begin
      for (int i = 0; i < 16; i++) if (4'(i) >= fill) buffer[i] <= '0;
    end else if (state == sha256_pkg::ST_CLR) begin
      for (int i = 0; i < 16; i++) buffer[i] <= '0;
    end else if (state == sha256_pkg::ST_LEN) begin
      buffer[14] <= bit_length[63:32];
      buffer[15] <= bit_length[31:0];
    end
  end

  sha256_core u_core (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .blk  (buffer),
    .hash (hash),
    .done (done)
  );

endmodule

>>> design/sha256_checker.sv
// ----------------------------------------------------------------------------
// sha256_checker
// Port-level checks on beat ordering of the hash engine.
// ----------------------------------------------------------------------------
module sha256_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  // no input taken while digest beats are pending
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready) else $error("input ready during digest");

  // digest ends after its last beat
  a_end: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> !m_axis_tvalid)
    else $error("digest continues after last beat");

  // word index steps by one
  a_index: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
      (m_axis_tvalid && m_axis_tdata[34:32] == $past(m_axis_tdata[34:32]) + 3'd1))
    else $error("digest index out of step");

  // input beat is not followed by a digest beat next cycle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && !m_axis_tvalid) |=> !m_axis_tvalid)
    else $error("digest right after input beat");

endmodule

bind sha256_hash_engine_top sha256_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

>>> sim/sha256_hash_engine_top_tb.sv
// ----------------------------------------------------------------------------
// sha256_hash_engine_top_tb
// Self-checking bench for the SHA-256/224 stream engine. A directed table
// covers empty and short last words and oversize byte counts; padding
// boundary runs for both variants and random messages follow. Every digest
// beat is checked against an in-bench hash predictor.
// ----------------------------------------------------------------------------
module sha256_hash_engine_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  nbytes;
    logic        last;
  } msg_beat_t;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        fin;
  } dig_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_data = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tlast;

  sha256_hash_engine_top uut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
  );

  always #1 clk = ~clk;

  initial begin
    #3000000;
    $display("sha256_hash_engine_top_tb: done, errors");
    $finish;
  end

  // predictor state
  localparam logic [31:0] RCON [64] = '{
    32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
    32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
    32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
    32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
    32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
    32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
    32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
    32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
    32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
    32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
    32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
  localparam logic [31:0] IV256 [8] = '{32'h6a09e667,32'hbb67ae85,32'h3c6ef372,
    32'ha54ff53a,32'h510e527f,32'h9b05688c,32'h1f83d9ab,32'h5be0cd19};
  localparam logic [31:0] IV224 [8] = '{32'hc1059ed8,32'h367cd507,32'h3070dd17,
    32'hf70e5939,32'hffc00b31,32'h68581511,32'h64f98fa7,32'hbefa4fa4};

  logic        mdl_variant;
  logic [31:0] mdl_hash [8];
  logic [31:0] mdl_block [16];
  logic [5:0]  mdl_fill;
  logic [63:0] mdl_bits;
  dig_beat_t   digest_q [$];
  int          errors = 0;

  function automatic logic [31:0] rotr(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic hash_restart();
    for (int i = 0; i < 8; i++)
      mdl_hash[i] = (mdl_variant == sha256_pkg::VAR_SHA224) ? IV224[i] : IV256[i];
    mdl_fill = '0;
    mdl_bits = '0;
  endtask

  task automatic hash_block();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2, e, a;
    for (int t = 0; t < 16; t++) w[t] = mdl_block[t];
    for (int t = 16; t < 64; t++)
      w[t] = (rotr(w[t-2],17) ^ rotr(w[t-2],19) ^ (w[t-2] >> 10)) + w[t-7]
           + (rotr(w[t-15],7) ^ rotr(w[t-15],18) ^ (w[t-15] >> 3)) + w[t-16];
    for (int i = 0; i < 8; i++) v[i] = mdl_hash[i];
    for (int t = 0; t < 64; t++) begin
      e = v[4]; a = v[0];
      t1 = v[7] + (rotr(e,6) ^ rotr(e,11) ^ rotr(e,25)) + ((e & v[5]) ^ (~e & v[6]))
         + RCON[t] + w[t];
      t2 = (rotr(a,2) ^ rotr(a,13) ^ rotr(a,22)) + ((a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) mdl_hash[i] += v[i];
  endtask

  task automatic buffer_word(logic [31:0] w);
    mdl_block[mdl_fill[5:2]] = w;
    mdl_fill = mdl_fill + 6'd4;
    if (mdl_fill == 0) hash_block();
  endtask

  // advance the predictor by one message beat, queueing any digest
  task automatic predict_digest(msg_beat_t b);
    logic [2:0]  n;
    logic [31:0] keep, pad;
    int          cnt;
    if (!b.last) begin
      mdl_bits += 64'd32;
      buffer_word(b.word);
      return;
    end
    n = (b.nbytes > 3'd4) ? 3'd4 : b.nbytes;
    mdl_bits += 64'(n) * 64'd8;
    if (n == 3'd4) begin
      buffer_word(b.word);
      pad = 32'h8000_0000;
    end else begin
      keep = (n == 0) ? 32'h0 : (32'hffff_ffff << (32 - 8 * n));
      pad = (b.word & keep) | (32'h80 << (24 - 8 * n));
    end
    buffer_word(pad);
    if (mdl_fill != 0) begin
      for (int i = mdl_fill[5:2]; i < 16; i++) mdl_block[i] = '0;
      if (mdl_fill > 6'd56) begin
        hash_block();
        for (int i = 0; i < 16; i++) mdl_block[i] = '0;
      end
    end else begin
      for (int i = 0; i < 16; i++) mdl_block[i] = '0;
    end
    mdl_block[14] = mdl_bits[63:32];
    mdl_block[15] = mdl_bits[31:0];
    hash_block();
    cnt = (mdl_variant == sha256_pkg::VAR_SHA224) ? 7 : 8;
    for (int i = 0; i < cnt; i++)
      digest_q.push_back('{word: mdl_hash[i], idx: 3'(i), fin: (i == cnt - 1)});
    hash_restart();
  endtask

  // receiver: own stall pattern, check each accepted beat
  int stall_mode = 0;
  always @(negedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(0, 3) != 0);
      default: m_axis_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      dig_beat_t exp_b;
      if (digest_q.size() == 0) begin
        $display("%0t: digest beat with none expected: %h", $time, m_axis_tdata);
        errors++;
      end else begin
        exp_b = digest_q.pop_front();
        if (m_axis_tdata[31:0] !== exp_b.word) begin
          $display("%0t: digest word exp %h got %h", $time, exp_b.word, m_axis_tdata[31:0]);
          errors++;
        end
        if (m_axis_tdata[34:32] !== exp_b.idx || m_axis_tdata[39:35] !== 5'd0) begin
          $display("%0t: word index exp %0d got %0d", $time, exp_b.idx,
                   m_axis_tdata[39:32]);
          errors++;
        end
        if (m_axis_tlast !== exp_b.fin) begin
          $display("%0t: tlast exp %b got %b", $time, exp_b.fin, m_axis_tlast);
          errors++;
        end
      end
    end
  end

  // sender: hold a beat until taken; drop valid only for a gap
  int burst_left = 0;
  task automatic send_beat(msg_beat_t b);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      burst_left = $urandom_range(1, 12);
    end
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'd0, b.nbytes, b.word};
    s_axis_tlast  <= b.last;
    do @(posedge clk); while (!s_axis_tready);
    predict_digest(b);
    @(negedge clk);
  endtask

  task automatic drain_outputs();
    s_axis_tvalid <= 1'b0;
    while (digest_q.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic write_variant(logic v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    mdl_variant = v;
    hash_restart();
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_message(int nwords);
    msg_beat_t b;
    for (int i = 0; i < nwords; i++) begin
      b.word = $urandom();
      b.nbytes = (i == nwords - 1) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(0, 7));
      b.last = (i == nwords - 1);
      send_beat(b);
    end
  endtask

  // directed rows; digest of the empty message is known
  msg_beat_t dir_tbl [] = '{
    '{32'h0000_0000, 3'd0, 1'b1},                 // empty message, SHA-256
    '{32'h6162_63ff, 3'd3, 1'b1},                 // "abc", junk below valid bytes
    '{32'hffff_ffff, 3'd7, 1'b1},                 // oversize count on last word
    '{32'hffff_ffff, 3'd1, 1'b0},                 // short count, not last
    '{32'h0000_0000, 3'd2, 1'b1},
    '{32'h1234_5678, 3'd5, 1'b0},
    '{32'h9abc_def0, 3'd4, 1'b1}
  };

  initial begin
    msg_beat_t b;
    mdl_variant = sha256_pkg::VAR_SHA256;
    hash_restart();
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    foreach (dir_tbl[i]) begin
      stall_mode = i % 3;
      send_beat(dir_tbl[i]);
      if (i == 0 && digest_q.size() > 0 && digest_q[0].word !== 32'he3b0c442) begin
        $display("%0t: empty digest exp %h got %h", $time, 32'he3b0c442,
                 digest_q[0].word);
        errors++;
      end
    end
    drain_outputs();

    // padding boundaries: 13..17 words (one and two final blocks), both variants
    for (int v = 0; v < 2; v++) begin
      write_variant(v[0]);
      for (int n = 13; n <= 17; n++) send_message(n);
      drain_outputs();
    end

    // random messages across variant changes
    for (int ph = 0; ph < 4; ph++) begin
      write_variant((ph == 1 || ph == 2) ? sha256_pkg::VAR_SHA224 : sha256_pkg::VAR_SHA256);
      stall_mode = ph % 3;
      for (int m = 0; m < 3; m++) send_message($urandom_range(1, 20));
      drain_outputs();
    end

    // message in progress dropped by a variant write
    send_message(1);
    b = '{32'hdead_beef, 3'd4, 1'b0};
    send_beat(b);
    drain_outputs();
    write_variant(sha256_pkg::VAR_SHA224);
    send_message(3);
    drain_outputs();

    if (errors == 0) $display("sha256_hash_engine_top_tb: done, clean");
    else $display("sha256_hash_engine_top_tb: done, errors");
    $finish;
  end
endmodule

>>> filelist.f
design/sha256_pkg.sv
design/sha256_core.sv
design/sha256_hash_engine_top.sv
design/sha256_checker.sv
sim/sha256_hash_engine_top_tb.sv
